@@ design/tournament_branch_predictor_assert.svh @@
// Assertion macros shared by the tournament branch predictor RTL.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TBP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/tbp_pkg.sv @@
// Shared types, codes and constants of the tournament branch predictor.
package tbp_pkg;

   localparam int TABLE_ENTRIES_DEF = 2048;
   localparam int HISTORY_MAX_DEF   = 11;
   localparam int ADDRESS_WIDTH_DEF = 32;

   localparam int COUNT_W     = 32;
   localparam int RSP_DATA_W  = 72;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KIND         = 2'd0,
      CSR_TABLE_BITS   = 2'd1,
      CSR_HISTORY_BITS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_ALWAYS     = 3'd0,
      KIND_NEVER      = 3'd1,
      KIND_ONE_BIT    = 3'd2,
      KIND_BIMODAL    = 3'd3,
      KIND_GSHARE     = 3'd4,
      KIND_TOURNAMENT = 3'd5
   } kind_type;

   typedef struct packed {
      logic       one_bit;
      logic [1:0] bimodal;
      logic [1:0] chooser;
   } bim_entry_type;

   typedef struct packed {
      logic          predicted;
      logic          bim_we;
      bim_entry_type bim_wdata;
      logic          gsh_we;
      logic [1:0]    gsh_wdata;
   } train_result_type;

   localparam bim_entry_type BIM_ENTRY_RESET = '{one_bit: 1'b1, bimodal: 2'd3, chooser: 2'd3};
   localparam logic [1:0]    GSH_RESET       = 2'd3;

   localparam logic [2:0] KIND_RESET         = 3'd5;
   localparam logic [3:0] TABLE_BITS_RESET   = 4'd11;
   localparam logic [3:0] HISTORY_BITS_RESET = 4'd11;

endpackage

@@ design/tbp_ram.sv @@
// Single-port-write, registered-read table memory of the branch predictor.
module tbp_ram
   import tbp_pkg::*;
#(
   parameter int DEPTH = TABLE_ENTRIES_DEF,
   parameter int WIDTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/tbp_train.sv @@
// Prediction and table training logic for one branch.
module tbp_train
   import tbp_pkg::*;
(
   input  kind_type         kind,
   input  logic             taken,
   input  bim_entry_type    bim_entry,
   input  logic [1:0]       gsh_counter,
   output train_result_type result
);

   function automatic logic [1:0] counter_train(input logic [1:0] c, input logic up);
      logic [1:0] n;
      if (up) begin
         n = (c == 2'd3) ? c : c + 2'd1;
      end else begin
         n = (c == 2'd0) ? c : c - 2'd1;
      end
      return n;
   endfunction

   logic bim_pred;
   logic gsh_pred;

   assign bim_pred = bim_entry.bimodal[1];
   assign gsh_pred = gsh_counter[1];

   always_comb begin
      result           = '0;
      result.bim_wdata = bim_entry;
      result.gsh_wdata = gsh_counter;
      case (kind)
         KIND_NEVER: begin
            result.predicted = 1'b0;
         end
         KIND_ONE_BIT: begin
            result.predicted         = bim_entry.one_bit;
            result.bim_wdata.one_bit = taken;
            result.bim_we            = 1'b1;
         end
         KIND_BIMODAL: begin
            result.predicted         = bim_pred;
            result.bim_wdata.bimodal = counter_train(bim_entry.bimodal, taken);
            result.bim_we            = 1'b1;
         end
         KIND_GSHARE: begin
            result.predicted = gsh_pred;
            result.gsh_wdata = counter_train(gsh_counter, taken);
            result.gsh_we    = 1'b1;
         end
         KIND_TOURNAMENT: begin
            result.predicted = bim_entry.chooser[1] ? gsh_pred : bim_pred;
            if (bim_pred != gsh_pred) begin
               result.bim_wdata.chooser = counter_train(bim_entry.chooser, gsh_pred == taken);
            end
            result.bim_wdata.bimodal = counter_train(bim_entry.bimodal, taken);
            result.gsh_wdata         = counter_train(gsh_counter, taken);
            result.bim_we            = 1'b1;
            result.gsh_we            = 1'b1;
         end
         default: begin
            result.predicted = 1'b1;
         end
      endcase
   end

endmodule

@@ design/tournament_branch_predictor.sv @@
// Top level of the tournament branch predictor with bimodal and gshare components.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    branch address, outcome
//   rsp      out        rsp_tvalid/tready    prediction, correct flag, counts
//   csr      in         csr_valid/ready      register index and value
//
// One item is accepted per cycle while no stalled result holds the pipeline; each
// result moves through the s1 stage and the output register. Each item reads the
// tables at acceptance and writes them back as it leaves s1, with a forward path
// covering an immediately following item at the same entry. After reset a clearing
// pass loads the tables, accepting no item meanwhile. Configuration is always taken.
module tournament_branch_predictor
   import tbp_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int HISTORY_MAX   = HISTORY_MAX_DEF,
   parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // branch_address, outcome_taken, zero padding
   input  logic [((ADDRESS_WIDTH + 8) / 8) * 8 - 1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // predicted_taken, prediction_correct, correct_count, branch_count, zero padding
   output logic [RSP_DATA_W-1:0]                  rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_INDEX_W-1:0]                 csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int HW    = (IDX_W > HISTORY_MAX) ? IDX_W : HISTORY_MAX;

   kind_type               cfg_kind_ff;
   logic [3:0]             cfg_tib_ff;
   logic [3:0]             cfg_hb_ff;
   logic [HISTORY_MAX-1:0] hist_ff;
   logic [HISTORY_MAX-1:0] hist_in;

   logic                   clear_ff;
   logic [IDX_W-1:0]       clr_addr_ff;

   logic                   s1_valid_ff;
   kind_type               s1_kind_ff;
   logic                   s1_taken_ff;
   logic [IDX_W-1:0]       s1_bi_ff;
   logic [IDX_W-1:0]       s1_gi_ff;
   logic                   fwd_b_ff;
   bim_entry_type          fwd_bdata_ff;
   logic                   fwd_g_ff;
   logic [1:0]             fwd_gdata_ff;

   logic                   out_valid_ff;
   logic                   pred_ff;
   logic                   correct_ff;
   logic [COUNT_W-1:0]     hit_ff;
   logic [COUNT_W-1:0]     seen_ff;

   logic                   req_accept;
   logic                   s1_adv;
   logic [ADDRESS_WIDTH-1:0] req_addr;
   logic                   req_taken;
   logic [IDX_W-1:0]       tbl_mask;
   logic [HW-1:0]          hist_mask;
   logic [HW-1:0]          hist_ext;
   logic [IDX_W-1:0]       bi;
   logic [IDX_W-1:0]       gi;

   logic [$bits(bim_entry_type)-1:0] bim_rdata;
   logic [1:0]             gsh_rdata;
   bim_entry_type          bim_entry;
   logic [1:0]             gsh_counter;
   train_result_type       train;

   logic                   bim_we;
   logic [IDX_W-1:0]       bim_waddr;
   bim_entry_type          bim_wdata;
   logic                   gsh_we;
   logic [IDX_W-1:0]       gsh_waddr;
   logic [1:0]             gsh_wdata;
   logic                   train_bim_we;
   logic                   train_gsh_we;

   assign req_addr  = req_tdata[ADDRESS_WIDTH-1:0];
   assign req_taken = req_tdata[ADDRESS_WIDTH];

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clear_ff && (!s1_valid_ff || s1_adv);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      for (int j = 0; j < IDX_W; j++) begin
         tbl_mask[j] = int'(cfg_tib_ff) > j;
      end
      for (int j = 0; j < HW; j++) begin
         hist_mask[j] = int'(cfg_hb_ff) > j;
      end
   end

   assign hist_ext = HW'(hist_ff) & hist_mask;
   assign bi       = req_addr[IDX_W-1:0] & tbl_mask;
   assign gi       = req_addr[IDX_W-1:0] ^ hist_ext[IDX_W-1:0];
   assign hist_in  = HISTORY_MAX'({hist_ff, req_taken});

   assign bim_entry   = fwd_b_ff ? fwd_bdata_ff : bim_entry_type'(bim_rdata);
   assign gsh_counter = fwd_g_ff ? fwd_gdata_ff : gsh_rdata;

   tbp_train u_train (
      .kind        (s1_kind_ff),
      .taken       (s1_taken_ff),
      .bim_entry   (bim_entry),
      .gsh_counter (gsh_counter),
      .result      (train)
   );

   assign train_bim_we = s1_adv && train.bim_we;
   assign train_gsh_we = s1_adv && train.gsh_we;

   assign bim_we    = clear_ff || train_bim_we;
   assign bim_waddr = clear_ff ? clr_addr_ff : s1_bi_ff;
   assign bim_wdata = clear_ff ? BIM_ENTRY_RESET : train.bim_wdata;
   assign gsh_we    = clear_ff || train_gsh_we;
   assign gsh_waddr = clear_ff ? clr_addr_ff : s1_gi_ff;
   assign gsh_wdata = clear_ff ? GSH_RESET : train.gsh_wdata;

   tbp_ram #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH ($bits(bim_entry_type))
   ) u_bim_ram (
      .clock (clock),
      .we    (bim_we),
      .waddr (bim_waddr),
      .wdata (bim_wdata),
      .re    (req_accept),
      .raddr (bi),
      .rdata (bim_rdata)
   );

   tbp_ram #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH (2)
   ) u_gsh_ram (
      .clock (clock),
      .we    (gsh_we),
      .waddr (gsh_waddr),
      .wdata (gsh_wdata),
      .re    (req_accept),
      .raddr (gi),
      .rdata (gsh_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_kind_ff  <= kind_type'(KIND_RESET);
         cfg_tib_ff   <= TABLE_BITS_RESET;
         cfg_hb_ff    <= HISTORY_BITS_RESET;
         hist_ff      <= '0;
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hit_ff       <= '0;
         seen_ff      <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_KIND:         cfg_kind_ff <= kind_type'(csr_data[2:0]);
               CSR_TABLE_BITS:   cfg_tib_ff  <= csr_data;
               CSR_HISTORY_BITS: cfg_hb_ff   <= csr_data;
               default: ;
            endcase
         end
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               clear_ff <= 1'b0;
            end
         end
         if (req_accept && (cfg_kind_ff == KIND_GSHARE || cfg_kind_ff == KIND_TOURNAMENT)) begin
            hist_ff <= hist_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
            if (seen_ff != '1) begin
               seen_ff <= seen_ff + 1'b1;
            end
            if (train.predicted == s1_taken_ff && hit_ff != '1) begin
               hit_ff <= hit_ff + 1'b1;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff   <= cfg_kind_ff;
         s1_taken_ff  <= req_taken;
         s1_bi_ff     <= bi;
         s1_gi_ff     <= gi;
         fwd_b_ff     <= train_bim_we && (s1_bi_ff == bi);
         fwd_bdata_ff <= train.bim_wdata;
         fwd_g_ff     <= train_gsh_we && (s1_gi_ff == gi);
         fwd_gdata_ff <= train.gsh_wdata;
      end
      if (s1_adv) begin
         pred_ff    <= train.predicted;
         correct_ff <= train.predicted == s1_taken_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({seen_ff, hit_ff, correct_ff, pred_ff});

`include "tournament_branch_predictor_assert.svh"

   `TBP_ASSERT_SAME(a_no_accept_while_clearing, clear_ff, !req_tready, "accept while clearing")
   `TBP_ASSERT_SAME(a_hits_within_seen, 1'b1, hit_ff <= seen_ff, "hits exceed branches")
   `TBP_ASSERT_NEXT(a_seen_inc, s1_adv && ~&seen_ff, seen_ff == $past(seen_ff) + 1'b1, "count stuck")
   `TBP_ASSERT_NEXT(a_history_holds, !req_accept, $stable(hist_ff), "history moved while idle")

endmodule

@@ tb/tb_tournament_branch_predictor.sv @@
// Self-checking testbench for the tournament branch predictor.
module tb_tournament_branch_predictor
   import tbp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W  = ((ADDRESS_WIDTH_DEF + 8) / 8) * 8;
   localparam int SLOT_W = $clog2(TABLE_ENTRIES_DEF);
   localparam int HIST_W = HISTORY_MAX_DEF;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   class branch_scoreboard;
      typedef struct packed {
         logic         predicted;
         logic         correct;
         logic [31:0]  hits;
         logic [31:0]  seen;
      } verdict_type;

      bit              one_bit_tbl [TABLE_ENTRIES_DEF];
      bit [1:0]        bim_ctr [TABLE_ENTRIES_DEF];
      bit [1:0]        gsh_ctr [TABLE_ENTRIES_DEF];
      bit [1:0]        choice_ctr [TABLE_ENTRIES_DEF];
      bit [HIST_W-1:0] ghist;
      bit [31:0]       hits;
      bit [31:0]       seen;
      bit [2:0]        kind;
      bit [3:0]        index_bits;
      bit [3:0]        hist_bits;
      verdict_type     expected_verdicts [$];
      int              mismatches;
      int              checked;

      function new();
         for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
            one_bit_tbl[i] = BIM_ENTRY_RESET.one_bit;
            bim_ctr[i]     = BIM_ENTRY_RESET.bimodal;
            choice_ctr[i]  = BIM_ENTRY_RESET.chooser;
            gsh_ctr[i]     = GSH_RESET;
         end
         ghist      = '0;
         hits       = '0;
         seen       = '0;
         kind       = KIND_RESET;
         index_bits = TABLE_BITS_RESET;
         hist_bits  = HISTORY_BITS_RESET;
         mismatches = 0;
         checked    = 0;
      endfunction

      static function bit [1:0] train(bit [1:0] ctr, bit up);
         if (up) return (ctr == 2'd3) ? ctr : ctr + 2'd1;
         return (ctr == 2'd0) ? ctr : ctr - 2'd1;
      endfunction

      function void configure(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_KIND:         kind = value[2:0];
            CSR_TABLE_BITS:   index_bits = value;
            CSR_HISTORY_BITS: hist_bits = value;
            default: ;
         endcase
      endfunction

      function void note_branch(bit [31:0] addr, bit taken);
         bit [31:0]       imask;
         bit [31:0]       hmask;
         bit [3:0]        hb;
         bit [SLOT_W-1:0] bi;
         bit [SLOT_W-1:0] gi;
         bit              bim_p;
         bit              gsh_p;
         bit              pred;
         bit              shift;
         verdict_type     v;
         hb    = (hist_bits > HIST_W) ? 4'(HIST_W) : hist_bits;
         imask = (32'd1 << index_bits) - 32'd1;
         hmask = (32'd1 << hb) - 32'd1;
         bi    = SLOT_W'(addr & imask);
         gi    = SLOT_W'(addr ^ (32'(ghist) & hmask));
         bim_p = bim_ctr[bi][1];
         gsh_p = gsh_ctr[gi][1];
         shift = 1'b0;
         case (kind)
            KIND_NEVER: pred = 1'b0;
            KIND_ONE_BIT: begin
               pred = one_bit_tbl[bi];
               one_bit_tbl[bi] = taken;
            end
            KIND_BIMODAL: begin
               pred = bim_p;
               bim_ctr[bi] = train(bim_ctr[bi], taken);
            end
            KIND_GSHARE: begin
               pred = gsh_p;
               gsh_ctr[gi] = train(gsh_ctr[gi], taken);
               shift = 1'b1;
            end
            KIND_TOURNAMENT: begin
               pred = choice_ctr[bi][1] ? gsh_p : bim_p;
               if (bim_p != gsh_p) choice_ctr[bi] = train(choice_ctr[bi], gsh_p == taken);
               bim_ctr[bi] = train(bim_ctr[bi], taken);
               gsh_ctr[gi] = train(gsh_ctr[gi], taken);
               shift = 1'b1;
            end
            default: pred = 1'b1;
         endcase
         if (shift) ghist = {ghist[HIST_W-2:0], taken};
         if (seen != '1) seen++;
         if (pred == taken && hits != '1) hits++;
         v.predicted = pred;
         v.correct   = (pred == taken);
         v.hits      = hits;
         v.seen      = seen;
         expected_verdicts.push_back(v);
      endfunction

      task report_mismatch(string field, logic [63:0] want, logic [63:0] got);
         mismatches++;
         if (mismatches <= 20)
            $display("Mismatch at result %0d: %s expected %0h, got %0h", checked, field, want,
                     got);
      endtask

      task check_verdict(logic [RSP_DATA_W-1:0] data);
         verdict_type want;
         checked++;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected result", '0, data[63:0]);
            return;
         end
         want = expected_verdicts.pop_front();
         if (data[0] !== want.predicted)
            report_mismatch("predicted_taken", want.predicted, data[0]);
         if (data[1] !== want.correct)
            report_mismatch("prediction_correct", want.correct, data[1]);
         if (data[33:2] !== want.hits)
            report_mismatch("correct_count", want.hits, data[33:2]);
         if (data[65:34] !== want.seen)
            report_mismatch("branch_count", want.seen, data[65:34]);
      endtask
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   branch_scoreboard sb;
   int               items_sent = 0;
   int               burst_left = 0;
   logic [31:0]      site_addr [8];
   int               site_trip [8];
   int               site_pos [8];
   logic [5:0]       stall_phase = '0;
   logic [1:0]       ready_mode = '0;

   tournament_branch_predictor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_verdict(rsp_tdata);
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == '0) ready_mode <= 2'($urandom_range(0, 3));
      case (ready_mode)
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= (stall_phase[1:0] == 2'd0);
         default: rsp_tready <= ($urandom_range(0, 99) < 85);
      endcase
   end

   task send_branch(logic [31:0] addr, logic taken);
      req_tdata  <= REQ_W'({taken, addr});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_branch(addr, taken);
      items_sent++;
   endtask

   task pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 20);
      end
   endtask

   task write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value, bit last);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.configure(idx, value);
      if (last) csr_valid <= 1'b0;
   endtask

   task wait_drain();
      req_tvalid <= 1'b0;
      while (sb.expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [3:0] pick_width(logic [3:0] lo, logic [3:0] hi);
      case ($urandom_range(0, 4))
         0:       return 4'd0;
         1:       return lo;
         2:       return hi;
         3:       return 4'd15;
         default: return 4'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic logic [2:0] pick_kind(int phase);
      int r;
      r = $urandom_range(0, 9);
      if (phase < 8) return 3'(phase);
      if (r < 3) return KIND_TOURNAMENT;
      if (r < 5) return KIND_GSHARE;
      if (r < 7) return KIND_BIMODAL;
      return 3'($urandom_range(0, 7));
   endfunction

   task make_sites();
      logic [31:0] fresh;
      for (int i = 0; i < 8; i++) begin
         fresh = $urandom;
         if (i > 0 && $urandom_range(0, 2) == 0)
            site_addr[i] = {fresh[31:SLOT_W], site_addr[i-1][SLOT_W-1:0]};
         else if (i > 0 && $urandom_range(0, 2) == 0)
            site_addr[i] = site_addr[0] + 32'(4 * i);
         else
            site_addr[i] = fresh;
         site_trip[i] = $urandom_range(0, 9);
         site_pos[i]  = 0;
      end
   endtask

   task send_site(int s);
      logic taken;
      site_pos[s]++;
      if (site_trip[s] == 0) taken = ($urandom_range(0, 9) != 0);
      else taken = (site_pos[s] % site_trip[s]) != 0;
      send_branch(site_addr[s], taken);
   endtask

   initial begin
      int          phase;
      int          n_items;
      int          run;
      int          s;
      logic [2:0]  kind_val;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b1);
      for (int k = 0; k < 8; k++) begin
         if (k != KIND_TOURNAMENT) begin
            wait_drain();
            write_csr(CSR_KIND, 4'(k), 1'b1);
            send_branch(32'h0000_0000, 1'b1);
            send_branch(32'h0000_0000, 1'b0);
            send_branch(32'hFFFF_FFFF, 1'b0);
         end
      end

      phase = 0;
      while (items_sent < 1150) begin
         wait_drain();
         kind_val = pick_kind(phase);
         write_csr(CSR_KIND, {1'($urandom_range(0, 1)), kind_val}, 1'b0);
         write_csr(CSR_TABLE_BITS, pick_width(4'd4, 4'd11), 1'b0);
         if ($urandom_range(0, 3) == 0) begin
            write_csr(CSR_HISTORY_BITS, pick_width(4'd1, 4'd11), 1'b0);
            write_csr(CSR_SPARE, 4'($urandom_range(0, 15)), 1'b1);
         end else begin
            write_csr(CSR_HISTORY_BITS, pick_width(4'd1, 4'd11), 1'b1);
         end
         make_sites();
         n_items = $urandom_range(40, 150);
         while (n_items > 0) begin
            s   = $urandom_range(0, 7);
            run = $urandom_range(1, 8);
            for (int r = 0; r < run && n_items > 0; r++) begin
               if ($urandom_range(0, 9) == 0) send_branch($urandom, 1'($urandom_range(0, 1)));
               else send_site(s);
               n_items--;
               pace();
            end
         end
         phase++;
      end
      wait_drain();

      $display("Covered %0d branches in %0d random settings after the directed pass,", items_sent,
               phase);
      $display("every kind code and index/history widths 0..15; %0d results, %0d mismatches.",
               sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_verdicts.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/tbp_pkg.sv
design/tbp_ram.sv
design/tbp_train.sv
design/tournament_branch_predictor.sv
tb/tb_tournament_branch_predictor.sv
